// ----- rtl/bsqa_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded sample queue average: shared package
// Types, codes and constants used by the controller, datapath and checker.
// ----------------------------------------------------------------------------
package bsqa_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int DEPTH_DEFAULT = 64;
  localparam int REG_W         = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int SUM_W         = SAMPLE_BITS + REG_W;
  localparam int DIV_CNT_W     = $clog2(SUM_W);

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_AVG  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = CFG_IDX_W'(1);

  typedef struct packed {
    logic [1:0]                    op;
    logic signed [SAMPLE_BITS-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic                          push_accepted;
    logic                          queue_empty;
    logic signed [SAMPLE_BITS-1:0] popped_value;
    logic signed [SAMPLE_BITS-1:0] last_value;
    logic signed [SAMPLE_BITS-1:0] average_value;
    logic [REG_W-1:0]              average_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP_WAIT,
    ST_AVG,
    ST_DIV_INIT,
    ST_DIV,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic decode;
    logic pop_capture;
    logic avg_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       queue_empty;
    logic       avg_none;
    logic       avg_done;
    logic       div_last;
    logic       out_busy;
  } dp_status_t;

endpackage

// ----- rtl/bsqa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsqa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bsqa_datapath.sv -----
// ----------------------------------------------------------------------------
// Bounded sample queue average: datapath
// Queue pointers, configuration, sample store, accumulator, serial divider
// and the output register.
// ----------------------------------------------------------------------------
module bsqa_datapath #(
  parameter int DEPTH = bsqa_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsqa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bsqa_pkg::REG_W-1:0]     cfg_data_i,
  input  bsqa_pkg::in_item_t             in_data_i,
  input  bsqa_pkg::dp_cmd_t              cmd_i,
  output bsqa_pkg::dp_status_t           status_o,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output bsqa_pkg::out_item_t            out_data_o
);

  localparam int SB    = bsqa_pkg::SAMPLE_BITS;
  localparam int RW    = bsqa_pkg::REG_W;
  localparam int SW    = bsqa_pkg::SUM_W;
  localparam int DCW   = bsqa_pkg::DIV_CNT_W;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AW    = ((CNT_W > RW) ? CNT_W : RW) + 1;

  localparam logic [IDX_W:0]   DEPTH_W   = (IDX_W + 1)'(DEPTH);
  localparam logic [AW-1:0]    DEPTH_A   = AW'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [DCW-1:0]   DIV_LAST  = DCW'(SW - 1);

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[IDX_W-1:0];
  endfunction

  // control state
  logic [RW-1:0]    cap_q, cap_d;
  logic [RW-1:0]    win_q, win_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SB-1:0]    last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic             acc_vld_q, acc_vld_d;

  // per-item payload state
  logic [1:0]       op_q, op_d;
  logic [SB-1:0]    sample_q, sample_d;
  logic             acc_q, acc_d;
  logic             emp_q, emp_d;
  logic [SB-1:0]    pop_q, pop_d;
  logic [RW-1:0]    n_q, n_d;
  logic [RW-1:0]    iss_q, iss_d;
  logic [IDX_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [SW-1:0]    sum_q, sum_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [SW-1:0]    dvd_q, dvd_d;
  logic             neg_q, neg_d;
  logic [DCW-1:0]   div_cnt_q, div_cnt_d;
  bsqa_pkg::out_item_t out_q, out_d;

  // push geometry
  logic [AW-1:0]    cnt_w, cap_w, drop_w, keep_w;
  logic [IDX_W-1:0] push_head, push_addr;

  // average helpers
  logic [RW-1:0]    n_sel;
  logic             issue;
  logic [RW:0]      rem_sh;
  logic             qbit;
  logic [SW-1:0]    avg_full;
  logic [RW-1:0]    cfg_win;

  // sample store
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [SB-1:0]    ram_rdata;

  bsqa_ram #(
    .WIDTH (SB),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sample_q),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // drop the oldest entries so that at most capacity - 1 remain before the store
  always_comb begin
    cnt_w = AW'(count_q);
    cap_w = AW'(cap_q);
    if (cnt_w >= cap_w) begin
      drop_w = cnt_w - cap_w + AW'(1);
      keep_w = cap_w - AW'(1);
    end else begin
      drop_w = '0;
      keep_w = cnt_w;
    end
    push_head = wrap_add(head_q, IDX_W'(drop_w));
    push_addr = wrap_add(push_head, IDX_W'(keep_w));
  end

  always_comb begin
    if (AW'(count_q) < AW'(win_q)) begin
      n_sel = RW'(count_q);
    end else begin
      n_sel = win_q;
    end
  end

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_win = RW'(1);
    end else if (cfg_data_i > cap_q) begin
      cfg_win = cap_q;
    end else begin
      cfg_win = cfg_data_i;
    end
  end

  assign issue    = (iss_q != n_q);
  assign rem_sh   = {rem_q, dvd_q[SW-1]};
  assign qbit     = (rem_sh >= {1'b0, n_q});
  assign avg_full = neg_q ? (~dvd_q + SW'(1)) : dvd_q;

  always_comb begin
    cap_d       = cap_q;
    win_d       = win_q;
    head_d      = head_q;
    count_d     = count_q;
    last_d      = last_q;
    op_d        = op_q;
    sample_d    = sample_q;
    acc_d       = acc_q;
    emp_d       = emp_q;
    pop_d       = pop_q;
    n_d         = n_q;
    iss_d       = iss_q;
    rd_ptr_d    = rd_ptr_q;
    acc_vld_d   = 1'b0;
    sum_d       = sum_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    neg_d       = neg_q;
    div_cnt_d   = div_cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = push_addr;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bsqa_pkg::CFG_CAPACITY: begin
          if (AW'(cfg_data_i) > DEPTH_A) begin
            cap_d = RW'(DEPTH);
          end else begin
            cap_d = cfg_data_i;
          end
        end
        bsqa_pkg::CFG_WINDOW: win_d = cfg_win;
        default: ;
      endcase
    end

    if (cmd_i.load) begin
      op_d     = in_data_i.op;
      sample_d = in_data_i.sample_value;
      acc_d    = 1'b0;
      emp_d    = 1'b0;
      pop_d    = '0;
      n_d      = '0;
      rd_ptr_d = head_q;
    end

    if (cmd_i.decode) begin
      case (op_q)
        bsqa_pkg::OP_PUSH: begin
          if (cap_q != '0) begin
            ram_we  = 1'b1;
            head_d  = push_head;
            count_d = CNT_W'(keep_w + AW'(1));
            last_d  = sample_q;
            acc_d   = 1'b1;
          end
        end
        bsqa_pkg::OP_POP: begin
          if (count_q == '0) begin
            emp_d = 1'b1;
          end else begin
            ram_re  = 1'b1;
            head_d  = wrap_add(head_q, IDX_W'(1));
            count_d = count_q - CNT_W'(1);
          end
        end
        bsqa_pkg::OP_AVG: begin
          n_d   = n_sel;
          iss_d = '0;
          sum_d = '0;
        end
        default: ;
      endcase
    end

    if (cmd_i.pop_capture) begin
      pop_d = ram_rdata;
    end

    // read one entry a cycle; add the entry read in the previous cycle
    if (cmd_i.avg_step) begin
      if (issue) begin
        ram_re   = 1'b1;
        iss_d    = iss_q + RW'(1);
        rd_ptr_d = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + IDX_W'(1);
      end
      if (acc_vld_q) begin
        sum_d = sum_q + {{RW{ram_rdata[SB-1]}}, ram_rdata};
      end
      acc_vld_d = issue;
    end

    // divide the magnitude, restore the sign afterwards
    if (cmd_i.div_init) begin
      neg_d     = sum_q[SW-1];
      dvd_d     = sum_q[SW-1] ? (~sum_q + SW'(1)) : sum_q;
      rem_d     = '0;
      div_cnt_d = '0;
    end

    if (cmd_i.div_step) begin
      if (qbit) begin
        rem_d = RW'(rem_sh - {1'b0, n_q});
      end else begin
        rem_d = rem_sh[RW-1:0];
      end
      dvd_d     = {dvd_q[SW-2:0], qbit};
      div_cnt_d = div_cnt_q + DCW'(1);
    end

    if (cmd_i.out_load) begin
      out_valid_d         = 1'b1;
      out_d.push_accepted = acc_q;
      out_d.queue_empty   = emp_q;
      out_d.popped_value  = pop_q;
      out_d.last_value    = last_q;
      out_d.average_value = (n_q != '0) ? avg_full[SB-1:0] : '0;
      out_d.average_count = n_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= '0;
      win_q       <= RW'(1);
      head_q      <= '0;
      count_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      acc_vld_q   <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      win_q       <= win_d;
      head_q      <= head_d;
      count_q     <= count_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      acc_vld_q   <= acc_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    sample_q  <= sample_d;
    acc_q     <= acc_d;
    emp_q     <= emp_d;
    pop_q     <= pop_d;
    n_q       <= n_d;
    iss_q     <= iss_d;
    rd_ptr_q  <= rd_ptr_d;
    sum_q     <= sum_d;
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    neg_q     <= neg_d;
    div_cnt_q <= div_cnt_d;
    out_q     <= out_d;
  end

  assign status_o.op          = op_q;
  assign status_o.queue_empty = (count_q == '0);
  assign status_o.avg_none    = (count_q == '0) || (win_q == '0);
  assign status_o.avg_done    = !issue && !acc_vld_q;
  assign status_o.div_last    = (div_cnt_q == DIV_LAST);
  assign status_o.out_busy    = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/bsqa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bounded sample queue average: controller
// Sequences one item at a time through decode, store access, accumulation,
// division and the hand-off to the output register.
// ----------------------------------------------------------------------------
module bsqa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bsqa_pkg::dp_status_t status_i,
  output bsqa_pkg::dp_cmd_t    cmd_o
);

  bsqa_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsqa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bsqa_pkg::ST_DECODE;
        end
      end
      bsqa_pkg::ST_DECODE: begin
        if (status_i.op == bsqa_pkg::OP_POP && !status_i.queue_empty) begin
          state_d = bsqa_pkg::ST_POP_WAIT;
        end else if (status_i.op == bsqa_pkg::OP_AVG && !status_i.avg_none) begin
          state_d = bsqa_pkg::ST_AVG;
        end else begin
          state_d = bsqa_pkg::ST_FIN;
        end
      end
      bsqa_pkg::ST_POP_WAIT: state_d = bsqa_pkg::ST_FIN;
      bsqa_pkg::ST_AVG: begin
        if (status_i.avg_done) begin
          state_d = bsqa_pkg::ST_DIV_INIT;
        end
      end
      bsqa_pkg::ST_DIV_INIT: state_d = bsqa_pkg::ST_DIV;
      bsqa_pkg::ST_DIV: begin
        if (status_i.div_last) begin
          state_d = bsqa_pkg::ST_FIN;
        end
      end
      bsqa_pkg::ST_FIN: begin
        // wait for the output register to free up
        if (!status_i.out_busy) begin
          state_d = bsqa_pkg::ST_IDLE;
        end
      end
      default: state_d = bsqa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      bsqa_pkg::ST_IDLE:     cmd_o.load        = in_valid_i;
      bsqa_pkg::ST_DECODE:   cmd_o.decode      = 1'b1;
      bsqa_pkg::ST_POP_WAIT: cmd_o.pop_capture = 1'b1;
      bsqa_pkg::ST_AVG:      cmd_o.avg_step    = 1'b1;
      bsqa_pkg::ST_DIV_INIT: cmd_o.div_init    = 1'b1;
      bsqa_pkg::ST_DIV:      cmd_o.div_step    = 1'b1;
      bsqa_pkg::ST_FIN:      cmd_o.out_load    = !status_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsqa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != bsqa_pkg::ST_IDLE);

endmodule

// ----- rtl/bounded_sample_queue_average_core.sv -----
// ----------------------------------------------------------------------------
// Bounded sample queue average core
// Drop-oldest sample FIFO with pop and window-average operations.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A push, an unknown operation or a pop of
// an empty queue goes from decode straight to the final state; a pop also
// passes a wait state, as the sample store has a registered read port. An
// average walks its averaged entries through the single store read port,
// one a cycle, then a bit-serial divider produces one quotient bit per cycle
// (31 quotient bits for 24-bit samples). The result sits in an output
// register, so the next item is taken while a result still waits. The store
// needs no clearing after reset.
module bounded_sample_queue_average_core #(
  parameter int DEPTH = bsqa_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsqa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bsqa_pkg::REG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bsqa_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bsqa_pkg::out_item_t            out_data_o
);

  bsqa_pkg::dp_cmd_t    cmd;
  bsqa_pkg::dp_status_t status;

  bsqa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bsqa_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/bsqa_checker.sv -----
// ----------------------------------------------------------------------------
// Bounded sample queue average: port checker
// Assertions on the core's ports, attached by bind.
// ----------------------------------------------------------------------------
module bsqa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bsqa_pkg::out_item_t out_data_o
);

  // one item at a time: a transfer in makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.push_accepted |->
      !out_data_o.queue_empty && out_data_o.average_count == '0 &&
      out_data_o.popped_value == '0)
    else $error("push result carries fields of another operation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.queue_empty |->
      out_data_o.popped_value == '0 && out_data_o.average_count == '0)
    else $error("empty pop returned data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.average_count == '0 |->
      out_data_o.average_value == '0)
    else $error("average value without averaged entries");

endmodule

bind bounded_sample_queue_average_core bsqa_checker u_bsqa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// Bounded sample queue average: block-level testbench
// Sends push, pop, average and unused requests in random bursts. Each reply
// is predicted by an in-bench model of the bounded queue and checked field
// by field. Capacity and window settings change between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH        = bsqa_pkg::DEPTH_DEFAULT;
  localparam int SAMPLE_BITS  = bsqa_pkg::SAMPLE_BITS;
  localparam int REG_W        = bsqa_pkg::REG_W;
  localparam int CFG_IDX_W    = bsqa_pkg::CFG_IDX_W;
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 800;
  localparam int DRAIN_CYCLES = 120;
  localparam int TIMEOUT      = 16_000_000;

  localparam logic [1:0]           OP_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef logic [PTR_W-1:0] ptr_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [REG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  bsqa_pkg::in_item_t   in_data_i   = '0;
  logic                 out_stall_i = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  bsqa_pkg::out_item_t  out_data_o;

  bounded_sample_queue_average_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Queue model state and settings
  logic signed [SAMPLE_BITS-1:0] fifo_mem [DEPTH];
  ptr_t                          fifo_head;
  logic [REG_W-1:0]              fifo_count;
  logic signed [SAMPLE_BITS-1:0] newest_value;
  logic [REG_W-1:0]              cap_limit;
  logic [REG_W-1:0]              avg_window;

  bsqa_pkg::in_item_t  ops_to_send[$];
  bsqa_pkg::out_item_t reply_backlog[$];

  int mismatch_count  = 0;
  int replies_checked = 0;
  int reg_writes      = 0;
  int op_seen[4]      = '{default: 0};
  int push_refused    = 0;
  int pop_empty       = 0;
  int avg_full_depth  = 0;
  int hold_ticket     = 0;

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
    case (idx)
      bsqa_pkg::CFG_CAPACITY: cap_limit = (data > DEPTH) ? REG_W'(DEPTH) : data;
      bsqa_pkg::CFG_WINDOW: begin
        if (data == 0) avg_window = REG_W'(1);
        else if (data > cap_limit) avg_window = cap_limit;
        else avg_window = data;
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_queue_op(bsqa_pkg::in_item_t item);
    bsqa_pkg::out_item_t r;
    longint              acc;
    logic [REG_W-1:0]    n;
    r = '0;
    op_seen[item.op]++;
    case (item.op)
      bsqa_pkg::OP_PUSH: begin
        if (cap_limit != 0) begin
          // drop oldest until there is room below the limit
          while (fifo_count >= cap_limit && fifo_count > 0) begin
            fifo_head++;
            fifo_count--;
          end
          fifo_mem[ptr_t'(fifo_head + fifo_count)] = item.sample_value;
          fifo_count++;
          newest_value    = item.sample_value;
          r.push_accepted = 1'b1;
        end else begin
          push_refused++;
        end
      end
      bsqa_pkg::OP_POP: begin
        if (fifo_count == 0) begin
          r.queue_empty = 1'b1;
          pop_empty++;
        end else begin
          r.popped_value = fifo_mem[fifo_head];
          fifo_head++;
          fifo_count--;
        end
      end
      bsqa_pkg::OP_AVG: begin
        n   = (fifo_count > avg_window) ? avg_window : fifo_count;
        acc = 0;
        for (int i = 0; i < n; i++) acc += fifo_mem[ptr_t'(fifo_head + i)];
        if (n > 0) r.average_value = SAMPLE_BITS'(acc / longint'(n));
        r.average_count = n;
        if (n == DEPTH) avg_full_depth++;
      end
      default: ;
    endcase
    r.last_value = newest_value;
    reply_backlog = {reply_backlog, r};
  endfunction

  task automatic check_field(input string label, input logic [SAMPLE_BITS-1:0] want,
                             input logic [SAMPLE_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // Sender: bursts of transfers separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) apply_queue_op(in_data_i);
      // hold the payload while stalled
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (ops_to_send.size() != 0) begin
          in_data_i  <= ops_to_send.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks replies and stalls in segments of varying density
  bsqa_pkg::out_item_t want_reply;
  int                  hold_seen    = 0;
  int                  hold_left    = 0;
  int                  segment_left = 0;
  int                  stall_pct    = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      segment_left = 0;
      stall_pct    = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (reply_backlog.size() == 0) begin
          $display("%0t: reply with none awaited, expected none, actual %h", $time, out_data_o);
          mismatch_count++;
        end else begin
          want_reply = reply_backlog.pop_front();
          check_field("push_accepted", want_reply.push_accepted, out_data_o.push_accepted);
          check_field("queue_empty", want_reply.queue_empty, out_data_o.queue_empty);
          check_field("popped_value", want_reply.popped_value, out_data_o.popped_value);
          check_field("last_value", want_reply.last_value, out_data_o.last_value);
          check_field("average_value", want_reply.average_value, out_data_o.average_value);
          check_field("average_count", want_reply.average_count, out_data_o.average_count);
          replies_checked++;
        end
      end
      if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (segment_left == 0) begin
          segment_left = $urandom_range(20, 200);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end else begin
          segment_left--;
        end
        out_stall_i <= ($urandom_range(1, 100) <= stall_pct);
      end
    end
  end

  function automatic void queue_op(logic [1:0] op, logic [SAMPLE_BITS-1:0] value);
    bsqa_pkg::in_item_t it;
    it.op           = op;
    it.sample_value = value;
    ops_to_send     = {ops_to_send, it};
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_BITS'($urandom_range(0, 15));
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_op(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return bsqa_pkg::OP_PUSH;
    if (roll >= 96) return OP_UNUSED;
    return ($urandom_range(0, 1) != 0) ? bsqa_pkg::OP_POP : bsqa_pkg::OP_AVG;
  endfunction

  function automatic logic [REG_W-1:0] rand_capacity();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return REG_W'(1);
      2:       return REG_W'(2);
      3:       return REG_W'(DEPTH);
      4:       return REG_W'($urandom_range(DEPTH + 1, 127));
      default: return REG_W'($urandom_range(3, DEPTH - 1));
    endcase
  endfunction

  function automatic logic [REG_W-1:0] rand_window();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return REG_W'(1);
      2:       return REG_W'(127);
      3:       return REG_W'(DEPTH);
      default: return REG_W'($urandom_range(1, DEPTH));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg_write(idx, data);
    reg_writes++;
  endtask

  task automatic wait_idle();
    while (ops_to_send.size() != 0 || in_valid_i || reply_backlog.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin : stimulus
    int push_pct;
    int phase_items;
    int random_sent;
    int phase_no;
    fifo_head    = '0;
    fifo_count   = '0;
    newest_value = '0;
    cap_limit    = '0;
    avg_window   = REG_W'(1);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    // zero capacity: push refused, empty pop and average, unused operation
    queue_op(bsqa_pkg::OP_PUSH, SAMPLE_MAX);
    queue_op(bsqa_pkg::OP_POP, SAMPLE_MIN);
    queue_op(bsqa_pkg::OP_AVG, '0);
    queue_op(OP_UNUSED, SAMPLE_BITS'(24'hAAAAAA));
    wait_idle();
    // window written while capacity is zero is held at zero
    write_reg(bsqa_pkg::CFG_WINDOW, REG_W'(5));
    @(negedge clk_i);
    queue_op(bsqa_pkg::OP_AVG, '0);
    wait_idle();

    // capacity saturates to depth, zero window becomes one, spare indexes ignored
    write_reg(bsqa_pkg::CFG_CAPACITY, REG_W'(127));
    write_reg(bsqa_pkg::CFG_WINDOW, '0);
    write_reg(CFG_SPARE_LO, REG_W'(127));
    write_reg(CFG_SPARE_HI, REG_W'(85));
    @(negedge clk_i);
    queue_op(bsqa_pkg::OP_PUSH, SAMPLE_MAX);
    queue_op(bsqa_pkg::OP_PUSH, SAMPLE_MIN);
    queue_op(bsqa_pkg::OP_AVG, '0);
    queue_op(bsqa_pkg::OP_POP, '0);
    queue_op(bsqa_pkg::OP_POP, '0);
    queue_op(bsqa_pkg::OP_POP, '1);
    wait_idle();

    write_reg(bsqa_pkg::CFG_WINDOW, REG_W'(DEPTH));
    @(negedge clk_i);
    queue_op(bsqa_pkg::OP_PUSH, SAMPLE_MAX);
    queue_op(bsqa_pkg::OP_PUSH, SAMPLE_MAX);
    queue_op(bsqa_pkg::OP_PUSH, SAMPLE_MAX);
    queue_op(bsqa_pkg::OP_PUSH, SAMPLE_MIN);
    queue_op(bsqa_pkg::OP_PUSH, '1);
    queue_op(bsqa_pkg::OP_PUSH, SAMPLE_BITS'(1));
    queue_op(bsqa_pkg::OP_AVG, '0);
    wait_idle();

    // shrink capacity below the fill level; window keeps its old value
    write_reg(bsqa_pkg::CFG_CAPACITY, REG_W'(3));
    @(negedge clk_i);
    queue_op(bsqa_pkg::OP_AVG, '0);
    queue_op(bsqa_pkg::OP_PUSH, SAMPLE_BITS'(24'h123456));
    queue_op(bsqa_pkg::OP_AVG, '0);
    queue_op(OP_UNUSED, SAMPLE_BITS'(24'h555555));
    queue_op(bsqa_pkg::OP_POP, '0);
    wait_idle();

    random_sent = 0;
    phase_no    = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 1) != 0) begin
        write_reg(bsqa_pkg::CFG_CAPACITY, rand_capacity());
        write_reg(bsqa_pkg::CFG_WINDOW, rand_window());
      end else begin
        write_reg(bsqa_pkg::CFG_WINDOW, rand_window());
        write_reg(bsqa_pkg::CFG_CAPACITY, rand_capacity());
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI, REG_W'($urandom));
      push_pct    = $urandom_range(35, 75);
      phase_items = $urandom_range(40, 75);
      @(negedge clk_i);
      for (int k = 0; k < phase_items; k++) queue_op(pick_op(push_pct), rand_value());
      // long receiver hold-off so the block backs up and stalls its input
      if (phase_no == 1) hold_ticket <= hold_ticket + 1;
      random_sent += phase_items;
      phase_no++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Covered %0d pushes (%0d refused), %0d pops (%0d on empty),",
             op_seen[bsqa_pkg::OP_PUSH], push_refused, op_seen[bsqa_pkg::OP_POP], pop_empty);
    $display("  %0d averages (%0d over full depth), %0d unused ops",
             op_seen[bsqa_pkg::OP_AVG], avg_full_depth, op_seen[OP_UNUSED]);
    $display("%0d replies checked across %0d register writes, %0d mismatches",
             replies_checked, reg_writes, mismatch_count);
    if (mismatch_count == 0 && reply_backlog.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("Timed out with %0d replies outstanding", reply_backlog.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
